FILE: rtl/rbr_pkg.sv
// Package for the row bit-blit raster op block: row constants, op codes,
// config register indexes and the item structs.
// No dependencies; used by the interfaces, the datapath core and the top level.
`default_nettype none

package rbr_pkg;

  // Row geometry
  localparam int unsigned RowBits  = 4096;
  localparam int unsigned WordBits = 32;
  localparam int unsigned IdxW     = 7;
  localparam int unsigned LenW     = 13;
  localparam int unsigned ShiftW   = 14;
  localparam int unsigned RopW     = 3;
  localparam int unsigned PosW     = 16;  // signed source position width

  // Config port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = ShiftW;

  localparam logic [CfgIdxW-1:0] CfgRop       = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgShiftBits = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDestBits  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSrcBits   = 2'd3;

  // Raster op codes; codes 6 and 7 write nothing
  typedef enum logic [RopW-1:0] {
    RopSet    = 3'd0,
    RopSetNot = 3'd1,
    RopAnd    = 3'd2,
    RopOr     = 3'd3,
    RopAndNot = 3'd4,
    RopOrNot  = 3'd5
  } rop_e;

  typedef struct packed {
    logic [WordBits-1:0] dest_word;
    logic [IdxW-1:0]     word_index;
    logic [WordBits-1:0] src_upper;
    logic [WordBits-1:0] src_lower;
  } in_item_t;

  typedef struct packed {
    logic [RopW-1:0]          rop;
    logic signed [ShiftW-1:0] shift_bits;
    logic [LenW-1:0]          dest_bits;
    logic [LenW-1:0]          src_bits;
  } cfg_t;

  typedef struct packed {
    logic [WordBits-1:0] result_word;
    logic [WordBits-1:0] written_bits;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/rbr_if.sv
// Stream interfaces for the row bit-blit raster op block: input word channel
// and result channel, each with valid/ready. Depends on rbr_pkg.
`default_nettype none

interface rbr_in_if;
  import rbr_pkg::*;

  logic                valid;
  logic                ready;
  logic [WordBits-1:0] dest_word;
  logic [IdxW-1:0]     word_index;
  logic [WordBits-1:0] src_upper;
  logic [WordBits-1:0] src_lower;

  modport source (output valid, dest_word, word_index, src_upper, src_lower, input ready);
  modport sink   (input valid, dest_word, word_index, src_upper, src_lower, output ready);
endinterface

interface rbr_out_if;
  import rbr_pkg::*;

  logic                valid;
  logic                ready;
  logic [WordBits-1:0] result_word;
  logic [WordBits-1:0] written_bits;

  modport source (output valid, result_word, written_bits, input ready);
  modport sink   (input valid, result_word, written_bits, output ready);
endinterface

`default_nettype wire

FILE: rtl/row_bitblt_raster_op_top.sv
// Top level of the row bit-blit raster op block: config registers, input
// register, datapath core and result register. Depends on rbr_pkg, rbr_if, rbr_core.
//
//   channel   direction  transaction                      payload
//   in_i      sink       one destination word + sources   dest_word, word_index,
//                                                         src_upper, src_lower
//   out_o     source     one merged word                  result_word, written_bits
//   cfg_*     input      register write, no handshake     cfg_idx_i, cfg_wdata_i
//
// One transaction per clock sustained while out_o is not stalled; an accepted
// transaction passes the input register, then the result register, before
// out_o.valid rises and the result can be taken.
// The rate is set by the combinational core between the two registers.
// in_i.ready drops only when both registers are full and out_o is stalled.
// Reset clears valid flags and config registers to zero.
`default_nettype none

module row_bitblt_raster_op_top (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  rbr_in_if.sink                            in_i,
  rbr_out_if.source                         out_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [rbr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [rbr_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import rbr_pkg::*;

  cfg_t     cfg_q;
  in_item_t item_q;
  logic     item_valid_q;
  res_t     res_d;
  res_t     res_q;
  logic     res_valid_q;
  logic     res_load;
  logic     item_load;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgRop:       cfg_q.rop        <= cfg_wdata_i[RopW-1:0];
        CfgShiftBits: cfg_q.shift_bits <= $signed(cfg_wdata_i[ShiftW-1:0]);
        CfgDestBits:  cfg_q.dest_bits  <= cfg_wdata_i[LenW-1:0];
        CfgSrcBits:   cfg_q.src_bits   <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: result stage takes the input stage whenever it is free or drains
  assign res_load  = !res_valid_q || out_o.ready;
  assign in_i.ready = !item_valid_q || res_load;
  assign item_load = in_i.valid && in_i.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      item_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_load) begin
      item_q.dest_word  <= in_i.dest_word;
      item_q.word_index <= in_i.word_index;
      item_q.src_upper  <= in_i.src_upper;
      item_q.src_lower  <= in_i.src_lower;
    end
  end

  rbr_core u_core (
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load && item_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = res_valid_q;
  assign out_o.result_word  = res_q.result_word;
  assign out_o.written_bits = res_q.written_bits;

endmodule

`default_nettype wire

FILE: rtl/rbr_core.sv
// Combinational datapath of the row bit-blit: funnel shift of the source,
// per-bit range mask and raster op merge. Depends on rbr_pkg.
`default_nettype none

module rbr_core (
  input  rbr_pkg::in_item_t item_i,
  input  rbr_pkg::cfg_t     cfg_i,
  output rbr_pkg::res_t     res_o
);
  import rbr_pkg::*;

  logic [IdxW+4:0]          base;      // first row position of this word
  logic signed [PosW-1:0]   src_pos0;  // source position of bit 31
  logic [4:0]               off;
  logic [2*WordBits-1:0]    funnel;
  logic [WordBits-1:0]      src;
  logic [LenW-1:0]          dlen;
  logic [LenW-1:0]          slen;
  logic [WordBits-1:0]      wmask;
  logic [WordBits-1:0]      comb;
  logic [WordBits-1:0]      wmask_final;
  logic [IdxW+5:0]          dpos  [WordBits];
  logic signed [PosW-1:0]   spos  [WordBits];

  // Source alignment
  assign base     = {item_i.word_index, 5'b0};
  assign src_pos0 = $signed(PosW'(base)) -
                    $signed({{(PosW-ShiftW){cfg_i.shift_bits[ShiftW-1]}}, cfg_i.shift_bits});
  assign off      = src_pos0[4:0];
  assign funnel   = {item_i.src_upper, item_i.src_lower} << off;
  assign src      = funnel[2*WordBits-1:WordBits];

  // Lengths clamp at the row size
  assign dlen = (cfg_i.dest_bits > LenW'(RowBits)) ? LenW'(RowBits) : cfg_i.dest_bits;
  assign slen = (cfg_i.src_bits  > LenW'(RowBits)) ? LenW'(RowBits) : cfg_i.src_bits;

  // Per-bit write mask, bit 31 is the lowest row position
  always_comb begin
    for (int i = 0; i < WordBits; i++) begin
      dpos[i] = {1'b0, base} + (IdxW+6)'(i);
      spos[i] = src_pos0 + PosW'(i);
      wmask[WordBits-1-i] = (dpos[i] < (IdxW+6)'(dlen)) && !spos[i][PosW-1] &&
                            (spos[i] < $signed(PosW'(slen)));
    end
  end

  // Raster op; unused codes write nothing
  always_comb begin
    wmask_final = wmask;
    case (rop_e'(cfg_i.rop))
      RopSet:    comb = src;
      RopSetNot: comb = ~src;
      RopAnd:    comb = item_i.dest_word & src;
      RopOr:     comb = item_i.dest_word | src;
      RopAndNot: comb = item_i.dest_word & ~src;
      RopOrNot:  comb = item_i.dest_word | ~src;
      default: begin
        comb        = item_i.dest_word;
        wmask_final = '0;
      end
    endcase
  end

  assign res_o.result_word  = (comb & wmask_final) | (item_i.dest_word & ~wmask_final);
  assign res_o.written_bits = wmask_final;

endmodule

`default_nettype wire

FILE: rtl/rbr_checker.sv
// Port-level checker for the row bit-blit raster op top level, bound to it.
// Depends on rbr_pkg and row_bitblt_raster_op_top.
`default_nettype none

module rbr_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_i,
  input wire logic                         out_valid_i,
  input wire logic                         out_ready_i,
  input wire logic [rbr_pkg::WordBits-1:0] result_word_i,
  input wire logic [rbr_pkg::WordBits-1:0] written_bits_i
);
  import rbr_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(result_word_i) && $stable(written_bits_i))
    else $error("stalled result changed");

  // With the result stage empty the block always takes input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result stage");

  // An accepted transaction reaches the output through the input and result registers if the sink drains
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i ##1 out_ready_i) |=> out_valid_i)
    else $error("result missing after accepted transaction");

  // Draining without accepted input through the input and result registers leaves the result stage empty
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!(in_valid_i && in_ready_i) && out_ready_i) ##1
      (!(in_valid_i && in_ready_i) && out_ready_i)
      |=> !out_valid_i)
    else $error("result without accepted transaction");

endmodule

bind row_bitblt_raster_op_top rbr_checker u_rbr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .result_word_i  (out_o.result_word),
  .written_bits_i (out_o.written_bits)
);

`default_nettype wire
